[rtl/core/rpcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcp_pkg
// Shared types, codes and the character tables of the command parser.
// ----------------------------------------------------------------------------
package rpcp_pkg;

  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_GS  = 8'h1D;
  localparam logic [7:0] BYTE_SP  = 8'h20;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [4:0] {
    PH_TEXT, PH_ESC, PH_ESC_MODE, PH_ESC_UL, PH_ESC_FEED, PH_ESC_SPACE,
    PH_ESC_JUST, PH_BAND_M, PH_BAND_NL, PH_BAND_NH, PH_BAND_DATA, PH_ESC_TABLE,
    PH_ESC_C, PH_ESC_C_ARG, PH_ESC_EMPH, PH_GS, PH_GS_CUT, PH_GS_CUT_N,
    PH_GS_RAS, PH_RAS_M, PH_RAS_XL, PH_RAS_XH, PH_RAS_YL, PH_RAS_YH,
    PH_RAS_DATA, PH_GS_PRINT, PH_DEF_X, PH_DEF_Y, PH_DEF_DATA
  } phase_t;

  typedef enum logic [3:0] {
    EV_CHAR, EV_FEED, EV_CUT, EV_RAS_HDR, EV_RAS_BYTE, EV_BAND_HDR,
    EV_BAND_BYTE, EV_DEF_BYTE, EV_PRINT_STORED
  } kind_t;

  typedef struct packed {
    logic [15:0] height;
    logic [18:0] width;
    logic [7:0]  spacing;
    logic [1:0]  justify;
    logic        underline;
    logic        dbl_height;
    logic        dbl_width;
    logic        emphasis;
    logic [15:0] value;
    kind_t       kind;
  } evt_t;

  typedef struct packed {
    evt_t       ev0;
    evt_t       ev1;
    logic [1:0] count;
  } evt_pair_t;

  localparam logic [15:0] TAB437 [128] = '{
    16'h00C7,16'h00FC,16'h00E9,16'h00E2,16'h00E4,16'h00E0,16'h00E5,16'h00E7,
    16'h00EA,16'h00EB,16'h00E8,16'h00EF,16'h00EE,16'h00EC,16'h00C4,16'h00C5,
    16'h00C9,16'h00E6,16'h00C6,16'h00F4,16'h00F6,16'h00F2,16'h00FB,16'h00F9,
    16'h00FF,16'h00D6,16'h00DC,16'h00A2,16'h00A3,16'h00A5,16'h20A7,16'h0192,
    16'h00E1,16'h00ED,16'h00F3,16'h00FA,16'h00F1,16'h00D1,16'h00AA,16'h00BA,
    16'h00BF,16'h2310,16'h00AC,16'h00BD,16'h00BC,16'h00A1,16'h00AB,16'h00BB,
    16'h2591,16'h2592,16'h2593,16'h2502,16'h2524,16'h2561,16'h2562,16'h2556,
    16'h2555,16'h2563,16'h2551,16'h2557,16'h255D,16'h255C,16'h255B,16'h2510,
    16'h2514,16'h2534,16'h252C,16'h251C,16'h2500,16'h253C,16'h255E,16'h255F,
    16'h255A,16'h2554,16'h2569,16'h2566,16'h2560,16'h2550,16'h256C,16'h2567,
    16'h2568,16'h2564,16'h2565,16'h2559,16'h2558,16'h2552,16'h2553,16'h256B,
    16'h256A,16'h2518,16'h250C,16'h2588,16'h2584,16'h258C,16'h2590,16'h2580,
    16'h03B1,16'h00DF,16'h0393,16'h03C0,16'h03A3,16'h03C3,16'h00B5,16'h03C4,
    16'h03A6,16'h0398,16'h03A9,16'h03B4,16'h221E,16'h03C6,16'h03B5,16'h2229,
    16'h2261,16'h00B1,16'h2265,16'h2264,16'h2320,16'h2321,16'h00F7,16'h2248,
    16'h00B0,16'h2219,16'h00B7,16'h221A,16'h207F,16'h00B2,16'h25A0,16'h00A0
  };

  localparam logic [15:0] TAB860 [48] = '{
    16'h00C7,16'h00FC,16'h00E9,16'h00E2,16'h00E3,16'h00E0,16'h00C1,16'h00E7,
    16'h00EA,16'h00CA,16'h00E8,16'h00CD,16'h00D4,16'h00EC,16'h00C3,16'h00C2,
    16'h00C9,16'h00C0,16'h00C8,16'h00F4,16'h00F5,16'h00F2,16'h00DA,16'h00F9,
    16'h00CC,16'h00D5,16'h00DC,16'h00A2,16'h00A3,16'h00D9,16'h20A7,16'h00D3,
    16'h00E1,16'h00ED,16'h00F3,16'h00FA,16'h00F1,16'h00D1,16'h00AA,16'h00BA,
    16'h00BF,16'h00D2,16'h00AC,16'h00BD,16'h00BC,16'h00A1,16'h00AB,16'h00BB
  };

  // Table 860 applies only when the selected code table is exactly 3.
  function automatic logic [15:0] map_char(input logic [7:0] c, input logic [7:0] tbl);
    logic [15:0] r;
    begin
      if (!c[7]) begin
        r = {8'h00, c};
      end else if (tbl == 8'd3 && c < 8'hB0) begin
        r = TAB860[6'(c - 8'h80)];
      end else begin
        r = TAB437[c[6:0]];
      end
      return r;
    end
  endfunction

endpackage

[rtl/core/rpcp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcp_parser
// Command state machine, style and image counters; one byte per cycle while byte_valid is high.
// ----------------------------------------------------------------------------
module rpcp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  logic [7:0]          byte_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output rpcp_pkg::evt_pair_t events
);

  rpcp_pkg::phase_t phase, phase_next;
  logic [3:0]  style, style_next;   // b0 emph, b1 dbl width, b2 dbl height, b3 ul
  logic [1:0]  justify, justify_next;
  logic [8:0]  spacing, spacing_next; // bit 8 marks automatic spacing
  logic [7:0]  code_table, code_table_next;
  logic [7:0]  column, column_next;
  logic [7:0]  wrap;
  logic [7:0]  mode_byte, mode_byte_next;
  logic [15:0] width_acc, width_acc_next;
  logic [15:0] height_acc, height_acc_next;
  logic [31:0] remaining, remaining_next;
  logic [7:0]  stored_w, stored_w_next;
  logic [7:0]  stored_h, stored_h_next;
  logic        stored_ok, stored_ok_next;

  logic [7:0]  b;
  logic        band_wide;
  logic [15:0] width_hi;
  logic [15:0] height_hi;
  logic [17:0] band_bytes;
  logic [31:0] ras_bytes;
  logic [15:0] def_prod;
  logic [31:0] rem_dec;
  logic [7:0]  col_inc;
  logic        wrap_hit;

  assign b         = byte_data;
  assign band_wide = (mode_byte == 8'd32) || (mode_byte == 8'd33);
  assign width_hi  = {b, width_acc[7:0]};
  assign height_hi = {b, height_acc[7:0]};
  assign band_bytes = band_wide ? ({2'b00, width_hi} + {1'b0, width_hi, 1'b0})
                                : {2'b00, width_hi};
  assign ras_bytes = width_acc * height_hi;
  assign def_prod  = stored_w * b;
  assign rem_dec   = (remaining != 32'd0) ? remaining - 32'd1 : 32'd0;
  assign col_inc   = (column != 8'hFF) ? column + 8'd1 : column;
  assign wrap_hit  = (wrap != 8'd0) && (col_inc >= wrap);

  // Next phase.
  always_comb begin
    phase_next = rpcp_pkg::PH_TEXT;
    unique case (phase)
      rpcp_pkg::PH_TEXT: begin
        if (b == rpcp_pkg::BYTE_ESC) phase_next = rpcp_pkg::PH_ESC;
        else if (b == rpcp_pkg::BYTE_GS) phase_next = rpcp_pkg::PH_GS;
      end
      rpcp_pkg::PH_ESC: begin
        unique case (b)
          8'h45:   phase_next = rpcp_pkg::PH_ESC_EMPH;
          8'h2D:   phase_next = rpcp_pkg::PH_ESC_UL;
          8'h64:   phase_next = rpcp_pkg::PH_ESC_FEED;
          8'h74:   phase_next = rpcp_pkg::PH_ESC_TABLE;
          8'h63:   phase_next = rpcp_pkg::PH_ESC_C;
          8'h33:   phase_next = rpcp_pkg::PH_ESC_SPACE;
          8'h21:   phase_next = rpcp_pkg::PH_ESC_MODE;
          8'h2A:   phase_next = rpcp_pkg::PH_BAND_M;
          8'h61:   phase_next = rpcp_pkg::PH_ESC_JUST;
          default: phase_next = rpcp_pkg::PH_TEXT;
        endcase
      end
      rpcp_pkg::PH_ESC_C:
        if (b == 8'h34 || b == 8'h35) phase_next = rpcp_pkg::PH_ESC_C_ARG;
      rpcp_pkg::PH_BAND_M:  phase_next = rpcp_pkg::PH_BAND_NL;
      rpcp_pkg::PH_BAND_NL: phase_next = rpcp_pkg::PH_BAND_NH;
      rpcp_pkg::PH_BAND_NH:
        if (band_bytes != 18'd0) phase_next = rpcp_pkg::PH_BAND_DATA;
      rpcp_pkg::PH_BAND_DATA, rpcp_pkg::PH_RAS_DATA, rpcp_pkg::PH_DEF_DATA:
        if (rem_dec != 32'd0) phase_next = phase;
      rpcp_pkg::PH_GS: begin
        if (b == 8'h56) phase_next = rpcp_pkg::PH_GS_CUT;
        else if (b == 8'h76) phase_next = rpcp_pkg::PH_GS_RAS;
        else if (b == 8'h2A) phase_next = rpcp_pkg::PH_DEF_X;
        else if (b == 8'h2F) phase_next = rpcp_pkg::PH_GS_PRINT;
      end
      rpcp_pkg::PH_GS_CUT:
        if (b == 8'd65 || b == 8'd66) phase_next = rpcp_pkg::PH_GS_CUT_N;
      rpcp_pkg::PH_GS_RAS:
        if (b == 8'h30) phase_next = rpcp_pkg::PH_RAS_M;
      rpcp_pkg::PH_RAS_M:  phase_next = rpcp_pkg::PH_RAS_XL;
      rpcp_pkg::PH_RAS_XL: phase_next = rpcp_pkg::PH_RAS_XH;
      rpcp_pkg::PH_RAS_XH: phase_next = rpcp_pkg::PH_RAS_YL;
      rpcp_pkg::PH_RAS_YL: phase_next = rpcp_pkg::PH_RAS_YH;
      rpcp_pkg::PH_RAS_YH:
        if (ras_bytes != 32'd0) phase_next = rpcp_pkg::PH_RAS_DATA;
      rpcp_pkg::PH_DEF_X: phase_next = rpcp_pkg::PH_DEF_Y;
      rpcp_pkg::PH_DEF_Y:
        if (def_prod != 16'd0) phase_next = rpcp_pkg::PH_DEF_DATA;
      default: phase_next = rpcp_pkg::PH_TEXT;
    endcase
  end

  // Data registers and events.
  always_comb begin
    rpcp_pkg::evt_t base;
    rpcp_pkg::evt_t e0;
    rpcp_pkg::evt_t e1;
    logic [1:0] n;
    base = '0;
    base.emphasis   = style[0];
    base.dbl_width  = style[1];
    base.dbl_height = style[2];
    base.underline  = style[3];
    base.justify    = justify;
    base.spacing    = spacing[8] ? 8'd0 : spacing[7:0];
    e0 = base;
    e1 = base;
    e1.kind  = rpcp_pkg::EV_FEED;
    e1.value = 16'd1;
    n = 2'd0;
    style_next      = style;
    justify_next    = justify;
    spacing_next    = spacing;
    code_table_next = code_table;
    column_next     = column;
    mode_byte_next  = mode_byte;
    width_acc_next  = width_acc;
    height_acc_next = height_acc;
    remaining_next  = remaining;
    stored_w_next   = stored_w;
    stored_h_next   = stored_h;
    stored_ok_next  = stored_ok;
    unique case (phase)
      rpcp_pkg::PH_TEXT: begin
        if (b == rpcp_pkg::BYTE_LF) begin
          e0.kind = rpcp_pkg::EV_FEED; e0.value = 16'd1; n = 2'd1;
          column_next = 8'd0;
        end else if (b >= rpcp_pkg::BYTE_SP && b != rpcp_pkg::BYTE_ESC
                     && b != rpcp_pkg::BYTE_GS) begin
          e0.kind = rpcp_pkg::EV_CHAR;
          e0.value = rpcp_pkg::map_char(b, code_table);
          if (wrap_hit) begin
            n = 2'd2; column_next = 8'd0;
          end else begin
            n = 2'd1; column_next = col_inc;
          end
        end
      end
      rpcp_pkg::PH_ESC: begin
        if (b == 8'h40) begin
          style_next = 4'd0; justify_next = 2'd0; spacing_next = 9'h100;
        end else if (b == 8'h32) begin
          spacing_next = 9'd30;
        end else if (b == 8'h69 || b == 8'h6D) begin
          e0.kind = rpcp_pkg::EV_CUT; n = 2'd1;
        end
      end
      rpcp_pkg::PH_ESC_MODE: style_next = {b[7], b[4], b[5], b[3]};
      rpcp_pkg::PH_ESC_UL:
        style_next[3] = !(b == 8'd0 || b == 8'd48);
      rpcp_pkg::PH_ESC_EMPH: style_next[0] = b[0];
      rpcp_pkg::PH_ESC_FEED: begin
        if (b != 8'd0) begin
          e0.kind = rpcp_pkg::EV_FEED; e0.value = {8'h00, b}; n = 2'd1;
          column_next = 8'd0;
        end
      end
      rpcp_pkg::PH_ESC_SPACE: spacing_next = {1'b0, b};
      rpcp_pkg::PH_ESC_JUST: begin
        if (b == 8'd1 || b == 8'd49) justify_next = 2'd1;
        else if (b == 8'd2 || b == 8'd50) justify_next = 2'd2;
        else justify_next = 2'd0;
      end
      rpcp_pkg::PH_ESC_TABLE: code_table_next = b;
      rpcp_pkg::PH_BAND_M, rpcp_pkg::PH_RAS_M: mode_byte_next = b;
      rpcp_pkg::PH_BAND_NL, rpcp_pkg::PH_RAS_XL: width_acc_next = {8'h00, b};
      rpcp_pkg::PH_BAND_NH: begin
        width_acc_next = width_hi;
        remaining_next = {14'd0, band_bytes};
        if (band_bytes != 18'd0) begin
          e0.kind = rpcp_pkg::EV_BAND_HDR; n = 2'd1;
          e0.width  = {3'd0, width_hi};
          e0.height = band_wide ? 16'd24 : 16'd8;
        end
      end
      rpcp_pkg::PH_BAND_DATA, rpcp_pkg::PH_RAS_DATA, rpcp_pkg::PH_DEF_DATA: begin
        if (phase == rpcp_pkg::PH_BAND_DATA) e0.kind = rpcp_pkg::EV_BAND_BYTE;
        else if (phase == rpcp_pkg::PH_RAS_DATA) e0.kind = rpcp_pkg::EV_RAS_BYTE;
        else e0.kind = rpcp_pkg::EV_DEF_BYTE;
        if (phase == rpcp_pkg::PH_DEF_DATA) stored_ok_next = 1'b1;
        e0.value = {8'h00, b}; n = 2'd1;
        remaining_next = rem_dec;
      end
      rpcp_pkg::PH_GS_CUT: begin
        if (!(b == 8'd65 || b == 8'd66)) begin
          e0.kind = rpcp_pkg::EV_CUT; n = 2'd1;
        end
      end
      rpcp_pkg::PH_GS_CUT_N: begin
        e0.kind = rpcp_pkg::EV_CUT; n = 2'd1;
      end
      rpcp_pkg::PH_RAS_XH: width_acc_next = width_hi;
      rpcp_pkg::PH_RAS_YL: height_acc_next = {8'h00, b};
      rpcp_pkg::PH_RAS_YH: begin
        height_acc_next = height_hi;
        remaining_next = ras_bytes;
        if (ras_bytes != 32'd0) begin
          e0.kind = rpcp_pkg::EV_RAS_HDR; n = 2'd1;
          e0.width  = {width_acc, 3'b000};
          e0.height = height_hi;
        end
      end
      rpcp_pkg::PH_GS_PRINT: begin
        if (stored_ok) begin
          e0.kind = rpcp_pkg::EV_PRINT_STORED; n = 2'd1;
          e0.width  = {8'd0, stored_w, 3'b000};
          e0.height = {5'd0, stored_h, 3'b000};
        end
      end
      rpcp_pkg::PH_DEF_X: stored_w_next = b;
      rpcp_pkg::PH_DEF_Y: begin
        stored_h_next  = b;
        remaining_next = {13'd0, def_prod, 3'b000};
        if (def_prod != 16'd0) stored_ok_next = 1'b0;
      end
      default: ;
    endcase
    events.ev0   = e0;
    events.ev1   = e1;
    events.count = byte_valid ? n : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= rpcp_pkg::PH_TEXT;
      style      <= 4'd0;
      justify    <= 2'd0;
      spacing    <= 9'h100;
      code_table <= 8'd0;
      column     <= 8'd0;
      wrap       <= 8'd0;
      mode_byte  <= 8'd0;
      width_acc  <= 16'd0;
      height_acc <= 16'd0;
      remaining  <= 32'd0;
      stored_w   <= 8'd0;
      stored_h   <= 8'd0;
      stored_ok  <= 1'b0;
    end else begin
      if (byte_valid) begin
        phase      <= phase_next;
        style      <= style_next;
        justify    <= justify_next;
        spacing    <= spacing_next;
        code_table <= code_table_next;
        mode_byte  <= mode_byte_next;
        width_acc  <= width_acc_next;
        height_acc <= height_acc_next;
        remaining  <= remaining_next;
        stored_w   <= stored_w_next;
        stored_h   <= stored_h_next;
        stored_ok  <= stored_ok_next;
      end
      if (cfg_we) begin
        wrap   <= cfg_wdata;
        column <= 8'd0;
      end else if (byte_valid) begin
        column <= column_next;
      end
    end
  end

endmodule

[rtl/core/rpcp_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcp_out_fifo
// Small result queue taking up to two events per cycle, handing out one while out_ready is high.
// ----------------------------------------------------------------------------
module rpcp_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  rpcp_pkg::evt_pair_t push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output rpcp_pkg::evt_t      out_evt,
  output logic                out_last
);

  rpcp_pkg::evt_t             mem  [rpcp_pkg::FIFO_DEPTH];
  logic                       last [rpcp_pkg::FIFO_DEPTH];
  logic [rpcp_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [rpcp_pkg::FIFO_AW:0]   count;
  logic                       pop;

  // Two free entries are needed, as one byte may cause two events.
  assign room      = count <= (rpcp_pkg::FIFO_AW + 1)'(rpcp_pkg::FIFO_DEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_evt   = mem[rd_ptr];
  assign out_last  = last[rd_ptr];
  assign wr_ptr1   = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr]  <= push.ev0;
      last[wr_ptr] <= push.count == 2'd1;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr1]  <= push.ev1;
      last[wr_ptr1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + rpcp_pkg::FIFO_AW'(push.count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (rpcp_pkg::FIFO_AW + 1)'(push.count)
               - (rpcp_pkg::FIFO_AW + 1)'(pop);
    end
  end

endmodule

[rtl/core/receipt_printer_command_parser_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receipt_printer_command_parser_core
// Parses a receipt-printer command byte stream into print events.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  s_axis    in         one command byte per beat
//  m_axis    out        one event per beat, tlast on the last event of a byte
//  cfg       in         wrap column count, written with cfg_we
//
// One byte is taken per cycle while s_axis_tready is high. The parser state
// and style registers update at the accepting edge, and the byte's one or
// two events enter a four-entry result queue, visible on m_axis in the next
// cycle if the queue was empty. s_axis_tready is high while the queue holds
// at most two events, so that both events of a byte always fit. With the
// output side stalled, the input is held off once three events wait, which
// is after at most three beats that each cause an event; bytes that cause no
// event are still taken. A byte that causes two events is handed out as two
// beats on m_axis. Reset is synchronous and needs no clearing pass.
//
module receipt_printer_command_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] event_kind, [19:4] event_value, [20] style_emphasis,
  // [21] style_double_width, [22] style_double_height, [23] style_underline,
  // [25:24] justify, [33:26] feed_spacing, [52:34] image_width_dots,
  // [68:53] image_height_dots, [71:69] zero
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  rpcp_pkg::evt_pair_t events;
  rpcp_pkg::evt_t      head;
  logic                accept;

  // A byte is taken when it is valid and the queue can absorb both possible events.
  assign accept = s_axis_tvalid && s_axis_tready;

  rpcp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (accept),
    .byte_data  (s_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .events     (events)
  );

  rpcp_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (events),
    .room      (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_evt   (head),
    .out_last  (m_axis_tlast)
  );

  // The event struct is laid out so that it maps straight onto tdata.
  assign m_axis_tdata = {3'b000, head};

endmodule

[sim/receipt_printer_command_parser_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receipt_printer_command_parser_core_tb
// Self-checking bench for the receipt-printer command parser. A byte queue
// feeds the input stream; every accepted byte is run through a parser model
// held in this bench, and every output beat is checked field by field
// against the oldest predicted event. The run steps through several wrap
// settings and idling mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module receipt_printer_command_parser_core_tb;
  import rpcp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  // Predicted event together with its end-of-run mark.
  typedef struct packed {
    logic last;
    evt_t ev;
  } exp_event_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  logic [7:0]  cmd_bytes_q [$];
  exp_event_t  event_q [$];

  int unsigned cyc_cnt;
  int unsigned bytes_taken;
  int unsigned events_seen;
  int unsigned fail_cnt;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;

  // Parser state as the bench sees it.
  phase_t      ph;
  logic [7:0]  wrap_cols;
  logic [3:0]  style;        // emphasis, double width, double height, underline
  logic [1:0]  just;
  logic        spc_auto;
  logic [7:0]  spc_dots;
  logic [7:0]  code_tbl;
  logic [7:0]  col_cnt;
  logic [7:0]  img_mode;
  logic [15:0] width_acc;
  logic [15:0] height_acc;
  logic [31:0] remaining;
  logic [7:0]  def_w;
  logic [7:0]  def_h;
  logic        def_present;

  receipt_printer_command_parser_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
  end

  // Safety net: the slowest legal run is far shorter than this.
  initial begin
    wait (cyc_cnt >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cyc_cnt);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Event prediction
  // --------------------------------------------------------------------------
  function automatic logic [15:0] code_point(input logic [7:0] c);
    if (!c[7]) return {8'h00, c};
    if (code_tbl == 8'd3 && c < 8'hB0) return TAB860[6'(c - 8'h80)];
    return TAB437[c[6:0]];
  endfunction

  task automatic post_event(input kind_t k, input logic [15:0] v,
                            input logic [18:0] w, input logic [15:0] h);
    exp_event_t e;
    e.last          = 1'b0;
    e.ev.kind       = k;
    e.ev.value      = v;
    e.ev.emphasis   = style[0];
    e.ev.dbl_width  = style[1];
    e.ev.dbl_height = style[2];
    e.ev.underline  = style[3];
    e.ev.justify    = just;
    e.ev.spacing    = spc_auto ? 8'd0 : spc_dots;
    e.ev.width      = w;
    e.ev.height     = h;
    event_q = {event_q, e};
  endtask

  task automatic clear_style();
    style    = 4'b0;
    just     = 2'd0;
    spc_auto = 1'b1;
    spc_dots = 8'd0;
  endtask

  // Advances the parser by one byte and queues the events it causes.
  task automatic parse_byte(input logic [7:0] b);
    int unsigned n0;
    phase_t      nx;
    logic [1:0]  per_col;
    n0 = event_q.size();
    nx = PH_TEXT;
    case (ph)
      PH_TEXT: begin
        if (b == BYTE_LF) begin
          post_event(EV_FEED, 16'd1, '0, '0);
          col_cnt = 8'd0;
        end else if (b == BYTE_ESC) begin
          nx = PH_ESC;
        end else if (b == BYTE_GS) begin
          nx = PH_GS;
        end else if (b >= BYTE_SP) begin
          post_event(EV_CHAR, code_point(b), '0, '0);
          if (col_cnt != 8'hFF) col_cnt = col_cnt + 1;
          if (wrap_cols != 0 && col_cnt >= wrap_cols) begin
            post_event(EV_FEED, 16'd1, '0, '0);
            col_cnt = 8'd0;
          end
        end
      end
      PH_ESC: begin
        case (b)
          8'h40: clear_style();
          8'h45: nx = PH_ESC_EMPH;
          8'h2D: nx = PH_ESC_UL;
          8'h64: nx = PH_ESC_FEED;
          8'h74: nx = PH_ESC_TABLE;
          8'h63: nx = PH_ESC_C;
          8'h33: nx = PH_ESC_SPACE;
          8'h32: begin
            spc_auto = 1'b0;
            spc_dots = 8'd30;
          end
          8'h21: nx = PH_ESC_MODE;
          8'h2A: nx = PH_BAND_M;
          8'h61: nx = PH_ESC_JUST;
          8'h69, 8'h6D: post_event(EV_CUT, 16'd0, '0, '0);
          default: ;
        endcase
      end
      PH_ESC_MODE:  style = {b[7], b[4], b[5], b[3]};
      PH_ESC_UL:    style[3] = !(b == 8'd0 || b == 8'd48);
      PH_ESC_EMPH:  style[0] = b[0];
      PH_ESC_FEED: begin
        if (b != 0) begin
          post_event(EV_FEED, {8'h00, b}, '0, '0);
          col_cnt = 8'd0;
        end
      end
      PH_ESC_SPACE: begin
        spc_auto = 1'b0;
        spc_dots = b;
      end
      PH_ESC_JUST: begin
        if (b == 8'd1 || b == 8'd49) just = 2'd1;
        else if (b == 8'd2 || b == 8'd50) just = 2'd2;
        else just = 2'd0;
      end
      PH_ESC_TABLE: code_tbl = b;
      PH_ESC_C:     if (b == 8'h34 || b == 8'h35) nx = PH_ESC_C_ARG;
      PH_ESC_C_ARG: ;
      PH_BAND_M: begin
        img_mode = b;
        nx = PH_BAND_NL;
      end
      PH_BAND_NL: begin
        width_acc = {8'h00, b};
        nx = PH_BAND_NH;
      end
      PH_BAND_NH: begin
        // Modes 32 and 33 carry three bytes per column, 24 dots high.
        per_col = (img_mode == 8'd32 || img_mode == 8'd33) ? 2'd3 : 2'd1;
        width_acc = width_acc + {b, 8'h00};
        remaining = width_acc * per_col;
        if (remaining != 0) begin
          post_event(EV_BAND_HDR, 16'd0, {3'b0, width_acc}, 16'(per_col * 8));
          nx = PH_BAND_DATA;
        end
      end
      PH_BAND_DATA, PH_RAS_DATA, PH_DEF_DATA: begin
        if (ph == PH_DEF_DATA) def_present = 1'b1;
        post_event(ph == PH_BAND_DATA ? EV_BAND_BYTE :
                   (ph == PH_RAS_DATA ? EV_RAS_BYTE : EV_DEF_BYTE),
                   {8'h00, b}, '0, '0);
        if (remaining != 0) remaining = remaining - 1;
        if (remaining != 0) nx = ph;
      end
      PH_GS: begin
        if (b == 8'h56) nx = PH_GS_CUT;
        else if (b == 8'h76) nx = PH_GS_RAS;
        else if (b == 8'h2A) nx = PH_DEF_X;
        else if (b == 8'h2F) nx = PH_GS_PRINT;
      end
      PH_GS_CUT: begin
        if (b == 8'd65 || b == 8'd66) nx = PH_GS_CUT_N;
        else post_event(EV_CUT, 16'd0, '0, '0);
      end
      PH_GS_CUT_N: post_event(EV_CUT, 16'd0, '0, '0);
      PH_GS_RAS:   if (b == 8'h30) nx = PH_RAS_M;
      PH_RAS_M: begin
        img_mode = b;
        nx = PH_RAS_XL;
      end
      PH_RAS_XL: begin
        width_acc = {8'h00, b};
        nx = PH_RAS_XH;
      end
      PH_RAS_XH: begin
        width_acc = width_acc + {b, 8'h00};
        nx = PH_RAS_YL;
      end
      PH_RAS_YL: begin
        height_acc = {8'h00, b};
        nx = PH_RAS_YH;
      end
      PH_RAS_YH: begin
        height_acc = height_acc + {b, 8'h00};
        remaining = width_acc * height_acc;
        if (remaining != 0) begin
          post_event(EV_RAS_HDR, 16'd0, {width_acc, 3'b000}, height_acc);
          nx = PH_RAS_DATA;
        end
      end
      PH_GS_PRINT: begin
        if (def_present)
          post_event(EV_PRINT_STORED, 16'd0, {8'h00, def_w, 3'b000},
                     {5'b0, def_h, 3'b000});
      end
      PH_DEF_X: begin
        def_w = b;
        nx = PH_DEF_Y;
      end
      PH_DEF_Y: begin
        // A zero-size define takes the new sizes but keeps the old presence.
        def_h = b;
        remaining = def_w * def_h * 8;
        if (remaining != 0) begin
          def_present = 1'b0;
          nx = PH_DEF_DATA;
        end
      end
      default: ;
    endcase
    ph = nx;
    if (event_q.size() > n0) event_q[event_q.size() - 1].last = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: one command byte per beat, predicted at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata);
        bytes_taken <= bytes_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_bytes_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cmd_bytes_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_seen     <= 0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Output monitor: each event beat against the oldest prediction.
  always @(posedge clk) begin
    exp_event_t e;
    evt_t       g;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      g = m_axis_tdata[68:0];
      events_seen++;
      if (event_q.size() == 0) begin
        $error("Unexpected event beat, kind 0x%0h", g.kind);
        fail_cnt++;
      end else begin
        e = event_q.pop_front();
        check_field("event_kind", e.ev.kind, g.kind);
        check_field("event_value", e.ev.value, g.value);
        check_field("style_emphasis", e.ev.emphasis, g.emphasis);
        check_field("style_double_width", e.ev.dbl_width, g.dbl_width);
        check_field("style_double_height", e.ev.dbl_height, g.dbl_height);
        check_field("style_underline", e.ev.underline, g.underline);
        check_field("justify", e.ev.justify, g.justify);
        check_field("feed_spacing", e.ev.spacing, g.spacing);
        check_field("image_width_dots", e.ev.width, g.width);
        check_field("image_height_dots", e.ev.height, g.height);
        check_field("last_of_run", e.last, m_axis_tlast);
        check_field("tdata padding", 0, m_axis_tdata[71:69]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic put(input logic [7:0] b);
    cmd_bytes_q = {cmd_bytes_q, b};
  endtask

  task automatic put_data(input int unsigned n);
    repeat (n) put(8'($urandom));
  endtask

  // One command or text fragment with random content; some of it is noise.
  task automatic random_command();
    int unsigned w;
    int unsigned h;
    logic [7:0]  pick [6];
    case ($urandom_range(15))
      0, 1, 2, 3, 4: repeat ($urandom_range(1, 5)) put(8'($urandom_range(8'h20, 8'hFF)));
      5: put($urandom_range(1) ? BYTE_LF : 8'($urandom_range(8'h00, 8'h1A)));
      6: begin
        pick = '{8'd0, 8'd1, 8'd2, 8'd49, 8'd50, 8'd48};
        put(BYTE_ESC);
        case ($urandom_range(3))
          0: begin put(8'h21); put(8'($urandom)); end
          1: begin put(8'h45); put(8'($urandom)); end
          2: begin put(8'h2D); put($urandom_range(1) ? pick[$urandom_range(5)] : 8'($urandom)); end
          default: begin put(8'h61); put($urandom_range(1) ? pick[$urandom_range(5)] : 8'($urandom)); end
        endcase
      end
      7: begin
        put(BYTE_ESC);
        case ($urandom_range(3))
          0: begin put(8'h33); put(8'($urandom)); end
          1: put(8'h32);
          2: put(8'h40);
          default: begin put(8'h74); put($urandom_range(1) ? 8'd3 : 8'($urandom)); end
        endcase
      end
      8: begin
        case ($urandom_range(3))
          0: begin put(BYTE_ESC); put(8'h64); put(8'($urandom_range(0, 3))); end
          1: begin put(BYTE_ESC); put($urandom_range(1) ? 8'h69 : 8'h6D); end
          2: begin put(BYTE_GS); put(8'h56); put(8'($urandom)); end
          default: begin
            put(BYTE_GS); put(8'h56); put(8'($urandom_range(65, 66))); put(8'($urandom));
          end
        endcase
      end
      9: begin
        pick = '{8'd0, 8'd1, 8'd32, 8'd33, 8'd32, 8'd33};
        w = $urandom_range(0, 3);
        put(BYTE_ESC); put(8'h2A);
        put($urandom_range(3) == 0 ? 8'($urandom) : pick[$urandom_range(5)]);
        // The band length depends on the mode, so the data is sized by the
        // predictor; here we just supply enough random bytes for three rows.
        put(8'(w)); put(8'h00);
        put_data(w * 3);
      end
      10: begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 2);
        put(BYTE_GS); put(8'h76); put(8'h30); put(8'($urandom));
        put(8'(w)); put(8'h00); put(8'(h)); put(8'h00);
        put_data(w * h);
      end
      11: begin
        if ($urandom_range(1)) begin
          w = $urandom_range(0, 1);
          h = $urandom_range(0, 2);
          put(BYTE_GS); put(8'h2A); put(8'(w)); put(8'(h));
          put_data(w * h * 8);
        end else begin
          put(BYTE_GS); put(8'h2F); put(8'($urandom));
        end
      end
      12: begin
        put(BYTE_ESC); put(8'h63);
        put($urandom_range(2) == 0 ? 8'($urandom) : 8'($urandom_range(8'h34, 8'h35)));
        put(8'($urandom));
      end
      13: begin put($urandom_range(1) ? BYTE_ESC : BYTE_GS); put(8'($urandom)); end
      default: put(8'($urandom));
    endcase
  endtask

  task automatic random_phase(input int unsigned n_bytes);
    int unsigned target;
    target = cmd_bytes_q.size() + n_bytes;
    while (cmd_bytes_q.size() < target) random_command();
    // A few spaces close most commands that are still open.
    repeat (5) put(8'h20);
  endtask

  // Lets every queued byte through and every predicted event out.
  task automatic drain();
    while (cmd_bytes_q.size() > 0 || s_axis_tvalid || event_q.size() > 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_wrap(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    wrap_cols = v;
    col_cnt   = 8'd0;
  endtask

  initial begin
    int unsigned seg;
    cyc_cnt       = 0;
    bytes_taken   = 0;
    events_seen   = 0;
    fail_cnt      = 0;
    snd_idle_pct  = 0;
    rcv_idle_pct  = 0;
    hold_req      = 0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'h00;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    m_axis_tready = 1'b0;
    ph            = PH_TEXT;
    wrap_cols     = 8'd0;
    clear_style();
    code_tbl      = 8'd0;
    col_cnt       = 8'd0;
    img_mode      = 8'd0;
    width_acc     = 16'd0;
    height_acc    = 16'd0;
    remaining     = 32'd0;
    def_w         = 8'd0;
    def_h         = 8'd0;
    def_present   = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_wrap(8'd0);

    // Directed part: print with nothing stored, control bytes, extremes of the
    // character range, table 860, zero feed, empty images, tall band and
    // function B cut.
    put(BYTE_GS); put(8'h2F); put(8'h00);
    put(8'h0D); put(8'h00); put(8'h1F);
    put(8'h20); put(8'hFF); put(8'h80);
    put(BYTE_ESC); put(8'h74); put(8'd3); put(8'h80); put(8'hAF); put(8'hB0);
    put(BYTE_ESC); put(8'h21); put(8'hB8); put(8'h41);
    put(BYTE_ESC); put(8'h64); put(8'h00);
    put(BYTE_ESC); put(8'h64); put(8'hFF);
    put(BYTE_GS); put(8'h76); put(8'h30); put(8'h00);
    put(8'hFF); put(8'hFF); put(8'h00); put(8'h00);
    put(BYTE_ESC); put(8'h2A); put(8'd33); put(8'h01); put(8'h00); put_data(3);
    put(BYTE_GS); put(8'h2A); put(8'h01); put(8'h01); put_data(8);
    put(BYTE_GS); put(8'h2A); put(8'h00); put(8'hFF);
    put(BYTE_GS); put(8'h2F); put(8'h00);
    put(BYTE_GS); put(8'h56); put(8'd65); put(8'h07);
    put(BYTE_ESC); put(8'h40); put(BYTE_LF);
    drain();

    // Random phases with varied idling and wrap widths.
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  write_wrap(8'd255); end
        1: begin snd_idle_pct = 68; rcv_idle_pct = 0;  write_wrap(8'd1);   end
        2: begin snd_idle_pct = 0;  rcv_idle_pct = 68; write_wrap(8'd10);  end
        3: begin snd_idle_pct = 36; rcv_idle_pct = 36; write_wrap(8'd0);   end
        4: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  write_wrap(8'd0);   end
        default: begin
          snd_idle_pct = 36; rcv_idle_pct = 36; write_wrap(8'($urandom_range(2, 40)));
        end
      endcase
      if (seg == 3) begin
        // Long line with wrapping off drives the column count into saturation.
        repeat (262) put(8'($urandom_range(8'h20, 8'hFF)));
      end
      if (seg == 4) begin
        // The sender keeps offering characters during the hold.
        hold_req++;
        repeat (8) put(8'($urandom_range(8'h20, 8'hFF)));
      end
      random_phase(seg == 3 ? 0 : 20);
      drain();
    end

    $display("Covered %0d command bytes and %0d events over six wrap settings,",
             bytes_taken, events_seen);
    $display("with idle input, stalled output and one %0d-cycle hold-off.", HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[receipt_printer_command_parser_core.f]
rtl/core/rpcp_pkg.sv
rtl/core/rpcp_parser.sv
rtl/core/rpcp_out_fifo.sv
rtl/core/receipt_printer_command_parser_core.sv
sim/receipt_printer_command_parser_core_tb.sv
